// File: rtl/eotf_pkg.sv
// eotf_pkg: types, constants and shared helpers for the early onset trend filter
// no dependencies; every rtl file refers to it by scoped names
`timescale 1ns / 1ps

package eotf_pkg;

  localparam int PRICE_BITS     = 24;
  localparam int COEF_FRAC_BITS = 30;

  localparam int CoefBits  = 32;
  localparam int KBits     = 24;
  localparam int ValBits   = 40;
  localparam int OperBits  = 41;
  localparam int LoBits    = 24;
  localparam int PartBits  = 25;
  localparam int ProdBits  = CoefBits + PartBits;
  localparam int AccBits   = 80;
  localparam int RatioBits = 64;
  localparam int DiffBits  = PRICE_BITS + 2;
  localparam int QBits     = 21;
  localparam int QWideBits = 25;

  localparam int HpShift   = COEF_FRAC_BITS;
  localparam int RoofShift = COEF_FRAC_BITS + 1;
  localparam int DecayFrac = 24;
  localparam int QFrac     = 16;

  localparam logic signed [CoefBits-1:0] DecayCoef = 32'sd16626178;

  // shared divider: 25 quotient bits, quotient held at 2^24
  localparam int DivSteps     = 25;
  localparam int DivCountBits = 5;
  localparam int DivPreShift  = 8;
  localparam logic [QWideBits-1:0] DivLimit = 25'd16777216;

  localparam logic signed [QWideBits-1:0] QuotMax = 25'sd1048575;
  localparam logic signed [QWideBits-1:0] QuotMin = -25'sd1048576;

  // configuration register indexes
  localparam logic [2:0] CfgHpGain       = 3'd0;
  localparam logic [2:0] CfgHpFbOne      = 3'd1;
  localparam logic [2:0] CfgHpFbTwo      = 3'd2;
  localparam logic [2:0] CfgSmoothGain   = 3'd3;
  localparam logic [2:0] CfgSmoothFbOne  = 3'd4;
  localparam logic [2:0] CfgSmoothFbTwo  = 3'd5;
  localparam logic [2:0] CfgQuotientK    = 3'd6;

  localparam logic signed [CoefBits-1:0] HpGainReset      = 32'sd1027580589;
  localparam logic signed [CoefBits-1:0] HpFbOneReset     = 32'sd2054147566;
  localparam logic signed [CoefBits-1:0] HpFbTwoReset     = 32'sd982434040;
  localparam logic signed [CoefBits-1:0] SmoothGainReset  = 32'sd84836352;
  localparam logic signed [CoefBits-1:0] SmoothFbOneReset = 32'sd1677528327;
  localparam logic signed [CoefBits-1:0] SmoothFbTwoReset = -32'sd688622844;
  localparam logic signed [KBits-1:0]    QuotientKReset   = 24'sd58982;

  typedef logic signed [AccBits-1:0]  acc_t;
  typedef logic signed [ValBits-1:0]  val_t;
  typedef logic signed [OperBits-1:0] oper_t;
  typedef logic signed [PartBits-1:0] part_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [CoefBits-1:0] coef_t;

  // one partial-product request to the multiply-accumulate unit
  typedef struct packed {
    logic issue;
    logic first;
    logic hi;
  } mac_op_t;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_HP_MUL   = 19'h00002,
    S_HP_WAIT  = 19'h00004,
    S_HP_RND   = 19'h00008,
    S_RF_MUL   = 19'h00010,
    S_RF_WAIT  = 19'h00020,
    S_RF_RND   = 19'h00040,
    S_PK_MUL   = 19'h00080,
    S_PK_WAIT  = 19'h00100,
    S_PK_CMP   = 19'h00200,
    S_NUM_MUL  = 19'h00400,
    S_NUM_WAIT = 19'h00800,
    S_NUM_ADD  = 19'h01000,
    S_DEN_MUL  = 19'h02000,
    S_DEN_WAIT = 19'h04000,
    S_DEN_ADD  = 19'h08000,
    S_DIV_GO   = 19'h10000,
    S_DIV_RUN  = 19'h20000,
    S_FIN      = 19'h40000
  } state_t;

  // round half up by 2^-s, then saturate to signed 40 bits
  function automatic val_t round_sat40(input acc_t v, input int unsigned s);
    acc_t half;
    acc_t t;
    half = acc_t'(1) <<< (s - 1);
    t    = (v + half) >>> s;
    if (t[AccBits-1:ValBits-1] == '0 || t[AccBits-1:ValBits-1] == '1) begin
      round_sat40 = t[ValBits-1:0];
    end else if (t[AccBits-1]) begin
      round_sat40 = {1'b1, {(ValBits-1){1'b0}}};
    end else begin
      round_sat40 = {1'b0, {(ValBits-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/early_onset_trend_filter.sv
// Early onset trend filter: one closing price in, one result out (roofing value,
// Q4.16 trend quotient and saturation flag). The sequencer carries each price
// through to its result and takes a new price only once it is back in idle,
// so one price is in work at a time: nine products pass in two 32 x 25
// partials each through the one multiply-accumulate unit, and the quotient comes
// from a 25-step restoring divider. close_stall is low only while idle; a finished
// result waits in the output register, and the next price is taken meanwhile, but
// the following result is held back until the previous one has been taken.
// Configuration writes land at once and belong to idle periods. Depends on
// eotf_pkg, eotf_mac and eotf_div.
`timescale 1ns / 1ps

module early_onset_trend_filter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    close_valid,
  output logic                                    close_stall,
  input  logic [eotf_pkg::PRICE_BITS-1:0]         close_price,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [eotf_pkg::ValBits-1:0]     roofing_value,
  output logic signed [eotf_pkg::QBits-1:0]       trend_quotient,
  output logic                                    quotient_saturated,
  input  logic                                    cfg_write,
  input  logic [2:0]                              cfg_index,
  input  logic [eotf_pkg::CoefBits-1:0]           cfg_data
);

  eotf_pkg::state_t state;
  eotf_pkg::state_t state_next;
  logic [2:0]       step;

  eotf_pkg::coef_t hp_gain;
  eotf_pkg::coef_t hp_feedback_one;
  eotf_pkg::coef_t hp_feedback_two;
  eotf_pkg::coef_t smooth_gain;
  eotf_pkg::coef_t smooth_feedback_one;
  eotf_pkg::coef_t smooth_feedback_two;
  logic signed [eotf_pkg::KBits-1:0] quotient_k;

  logic [eotf_pkg::PRICE_BITS-1:0] price;
  logic [eotf_pkg::PRICE_BITS-1:0] price_delay_one;
  logic [eotf_pkg::PRICE_BITS-1:0] price_delay_two;
  eotf_pkg::val_t highpass_delay_one;
  eotf_pkg::val_t highpass_delay_two;
  eotf_pkg::val_t roofing_delay_one;
  eotf_pkg::val_t roofing_delay_two;
  logic [eotf_pkg::ValBits-1:0] peak_level;

  eotf_pkg::val_t hp;
  eotf_pkg::val_t roof;
  logic [eotf_pkg::ValBits-1:0] peak_new;
  logic signed [eotf_pkg::RatioBits-1:0] num;
  logic signed [eotf_pkg::RatioBits-1:0] den;

  logic signed [eotf_pkg::DiffBits-1:0] diff;
  eotf_pkg::mac_op_t mac_op;
  eotf_pkg::coef_t   mac_a;
  eotf_pkg::oper_t   oper;
  eotf_pkg::part_t   mac_b;
  eotf_pkg::acc_t    acc;
  logic              last_step;

  logic [eotf_pkg::RatioBits-1:0] num_mag;
  logic [eotf_pkg::RatioBits-1:0] den_mag;
  logic                           div_busy;
  logic [eotf_pkg::QWideBits-1:0] div_q;

  logic [eotf_pkg::ValBits-1:0]   roof_mag;
  logic [eotf_pkg::ValBits-1:0]   decayed;
  logic [eotf_pkg::QWideBits-1:0] rounded_mag;
  logic signed [eotf_pkg::QWideBits-1:0] q_wide;
  logic signed [eotf_pkg::QWideBits-1:0] q_final;
  logic sat_flag;
  logic out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_gain             <= eotf_pkg::HpGainReset;
      hp_feedback_one     <= eotf_pkg::HpFbOneReset;
      hp_feedback_two     <= eotf_pkg::HpFbTwoReset;
      smooth_gain         <= eotf_pkg::SmoothGainReset;
      smooth_feedback_one <= eotf_pkg::SmoothFbOneReset;
      smooth_feedback_two <= eotf_pkg::SmoothFbTwoReset;
      quotient_k          <= eotf_pkg::QuotientKReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        eotf_pkg::CfgHpGain:      hp_gain             <= cfg_data;
        eotf_pkg::CfgHpFbOne:     hp_feedback_one     <= cfg_data;
        eotf_pkg::CfgHpFbTwo:     hp_feedback_two     <= cfg_data;
        eotf_pkg::CfgSmoothGain:  smooth_gain         <= cfg_data;
        eotf_pkg::CfgSmoothFbOne: smooth_feedback_one <= cfg_data;
        eotf_pkg::CfgSmoothFbTwo: smooth_feedback_two <= cfg_data;
        eotf_pkg::CfgQuotientK:   quotient_k <= cfg_data[eotf_pkg::KBits-1:0];
        default: ;
      endcase
    end
  end

  assign close_stall = (state != eotf_pkg::S_IDLE);
  assign out_free    = !result_valid || !result_stall;

  assign diff = $signed({2'b00, price})
              - $signed({1'b0, price_delay_one, 1'b0})
              + $signed({2'b00, price_delay_two});

  // operand selection for the shared multiplier
  always_comb begin
    mac_a     = '0;
    oper      = '0;
    last_step = (step == 3'd1);
    unique case (state)
      eotf_pkg::S_HP_MUL: begin
        last_step = (step == 3'd5);
        case (step[2:1])
          2'd0: begin
            mac_a = hp_gain;
            oper  = eotf_pkg::oper_t'(diff) <<< 8;
          end
          2'd1: begin
            mac_a = hp_feedback_one;
            oper  = eotf_pkg::oper_t'(highpass_delay_one);
          end
          default: begin
            mac_a = hp_feedback_two;
            oper  = -eotf_pkg::oper_t'(highpass_delay_two);
          end
        endcase
      end
      eotf_pkg::S_RF_MUL: begin
        last_step = (step == 3'd5);
        case (step[2:1])
          2'd0: begin
            mac_a = smooth_gain;
            oper  = eotf_pkg::oper_t'(hp) + eotf_pkg::oper_t'(highpass_delay_one);
          end
          2'd1: begin
            mac_a = smooth_feedback_one;
            oper  = {roofing_delay_one, 1'b0};
          end
          default: begin
            mac_a = smooth_feedback_two;
            oper  = {roofing_delay_two, 1'b0};
          end
        endcase
      end
      eotf_pkg::S_PK_MUL: begin
        mac_a = eotf_pkg::DecayCoef;
        oper  = {1'b0, peak_level};
      end
      eotf_pkg::S_NUM_MUL: begin
        mac_a = eotf_pkg::coef_t'(quotient_k);
        oper  = {1'b0, peak_new};
      end
      eotf_pkg::S_DEN_MUL: begin
        mac_a = eotf_pkg::coef_t'(quotient_k);
        oper  = eotf_pkg::oper_t'(roof);
      end
      default: ;
    endcase
  end

  assign mac_op.issue = (state == eotf_pkg::S_HP_MUL) || (state == eotf_pkg::S_RF_MUL)
                     || (state == eotf_pkg::S_PK_MUL) || (state == eotf_pkg::S_NUM_MUL)
                     || (state == eotf_pkg::S_DEN_MUL);
  assign mac_op.first = (step == 3'd0);
  assign mac_op.hi    = !step[0];
  assign mac_b = mac_op.hi
               ? eotf_pkg::part_t'($signed(oper[eotf_pkg::OperBits-1:eotf_pkg::LoBits]))
               : $signed({1'b0, oper[eotf_pkg::LoBits-1:0]});

  eotf_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  assign num_mag = num[eotf_pkg::RatioBits-1] ? eotf_pkg::RatioBits'(-num)
                                              : eotf_pkg::RatioBits'(num);
  assign den_mag = den[eotf_pkg::RatioBits-1] ? eotf_pkg::RatioBits'(-den)
                                              : eotf_pkg::RatioBits'(den);

  eotf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == eotf_pkg::S_DIV_GO),
    .dividend (num_mag),
    .divisor  (den_mag),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      eotf_pkg::S_IDLE:     if (close_valid) state_next = eotf_pkg::S_HP_MUL;
      eotf_pkg::S_HP_MUL:   if (last_step) state_next = eotf_pkg::S_HP_WAIT;
      eotf_pkg::S_HP_WAIT:  state_next = eotf_pkg::S_HP_RND;
      eotf_pkg::S_HP_RND:   state_next = eotf_pkg::S_RF_MUL;
      eotf_pkg::S_RF_MUL:   if (last_step) state_next = eotf_pkg::S_RF_WAIT;
      eotf_pkg::S_RF_WAIT:  state_next = eotf_pkg::S_RF_RND;
      eotf_pkg::S_RF_RND:   state_next = eotf_pkg::S_PK_MUL;
      eotf_pkg::S_PK_MUL:   if (last_step) state_next = eotf_pkg::S_PK_WAIT;
      eotf_pkg::S_PK_WAIT:  state_next = eotf_pkg::S_PK_CMP;
      eotf_pkg::S_PK_CMP:   state_next = eotf_pkg::S_NUM_MUL;
      eotf_pkg::S_NUM_MUL:  if (last_step) state_next = eotf_pkg::S_NUM_WAIT;
      eotf_pkg::S_NUM_WAIT: state_next = eotf_pkg::S_NUM_ADD;
      eotf_pkg::S_NUM_ADD:  state_next = eotf_pkg::S_DEN_MUL;
      eotf_pkg::S_DEN_MUL:  if (last_step) state_next = eotf_pkg::S_DEN_WAIT;
      eotf_pkg::S_DEN_WAIT: state_next = eotf_pkg::S_DEN_ADD;
      eotf_pkg::S_DEN_ADD:  state_next = eotf_pkg::S_DIV_GO;
      eotf_pkg::S_DIV_GO:   state_next = eotf_pkg::S_DIV_RUN;
      eotf_pkg::S_DIV_RUN:  if (!div_busy) state_next = eotf_pkg::S_FIN;
      eotf_pkg::S_FIN:      if (out_free) state_next = eotf_pkg::S_IDLE;
      default:              state_next = eotf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eotf_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (mac_op.issue) begin
        step <= last_step ? 3'd0 : step + 3'd1;
      end
    end
  end

  // peak tracker and quotient selection
  assign decayed  = acc[eotf_pkg::DecayFrac +: eotf_pkg::ValBits];
  assign roof_mag = roof[eotf_pkg::ValBits-1] ? eotf_pkg::ValBits'(-roof)
                                              : eotf_pkg::ValBits'(roof);
  assign rounded_mag = eotf_pkg::QWideBits'(({1'b0, div_q} + 26'd1) >> 1);

  always_comb begin
    sat_flag = 1'b0;
    if (peak_new == '0) begin
      q_wide = eotf_pkg::QWideBits'(quotient_k);
    end else if (den == '0) begin
      sat_flag = 1'b1;
      if (num == '0) begin
        q_wide = '0;
      end else if (num[eotf_pkg::RatioBits-1]) begin
        q_wide = eotf_pkg::QuotMin;
      end else begin
        q_wide = eotf_pkg::QuotMax;
      end
    end else if (num[eotf_pkg::RatioBits-1] != den[eotf_pkg::RatioBits-1]) begin
      q_wide = -$signed(rounded_mag);
    end else begin
      q_wide = $signed(rounded_mag);
    end
    q_final = q_wide;
    if (q_wide > eotf_pkg::QuotMax) begin
      q_final  = eotf_pkg::QuotMax;
      sat_flag = 1'b1;
    end else if (q_wide < eotf_pkg::QuotMin) begin
      q_final  = eotf_pkg::QuotMin;
      sat_flag = 1'b1;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    unique case (state)
      eotf_pkg::S_IDLE:    if (close_valid) price <= close_price;
      eotf_pkg::S_HP_RND:  hp   <= eotf_pkg::round_sat40(acc, eotf_pkg::HpShift);
      eotf_pkg::S_RF_RND:  roof <= eotf_pkg::round_sat40(acc, eotf_pkg::RoofShift);
      eotf_pkg::S_PK_CMP:  peak_new <= (roof_mag > decayed) ? roof_mag : decayed;
      eotf_pkg::S_NUM_ADD: begin
        num <= acc[eotf_pkg::RatioBits-1:0]
             + (eotf_pkg::RatioBits'(roof) <<< eotf_pkg::QFrac);
      end
      eotf_pkg::S_DEN_ADD: begin
        den <= acc[eotf_pkg::RatioBits-1:0]
             + eotf_pkg::RatioBits'({peak_new, {eotf_pkg::QFrac{1'b0}}});
      end
      default: ;
    endcase
  end

  // history
  always_ff @(posedge clk) begin
    if (rst) begin
      price_delay_one    <= '0;
      price_delay_two    <= '0;
      highpass_delay_one <= '0;
      highpass_delay_two <= '0;
      roofing_delay_one  <= '0;
      roofing_delay_two  <= '0;
      peak_level         <= '0;
    end else if (state == eotf_pkg::S_FIN && out_free) begin
      price_delay_two    <= price_delay_one;
      price_delay_one    <= price;
      highpass_delay_two <= highpass_delay_one;
      highpass_delay_one <= hp;
      roofing_delay_two  <= roofing_delay_one;
      roofing_delay_one  <= roof;
      peak_level         <= peak_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == eotf_pkg::S_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == eotf_pkg::S_FIN && out_free) begin
      roofing_value      <= roof;
      trend_quotient     <= q_final[eotf_pkg::QBits-1:0];
      quotient_saturated <= sat_flag;
    end
  end

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == eotf_pkg::S_FIN))
    else $error("result appeared without a finished request");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == eotf_pkg::S_IDLE) |-> !div_busy)
    else $error("divider still running while idle");

  a_peak_covers_roof: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (peak_level >= (roofing_value[eotf_pkg::ValBits-1]
      ? eotf_pkg::ValBits'(-roofing_value) : eotf_pkg::ValBits'(roofing_value))))
    else $error("peak level below roofing magnitude");

endmodule

// File: rtl/eotf_mac.sv
// eotf_mac: shared 32 x 25 signed multiplier with an 80-bit accumulator
// depends on eotf_pkg
`timescale 1ns / 1ps

module eotf_mac (
  input  logic              clk,
  input  logic              rst,
  input  eotf_pkg::mac_op_t op,
  input  eotf_pkg::coef_t   a,
  input  eotf_pkg::part_t   b,
  output eotf_pkg::acc_t    acc
);

  eotf_pkg::prod_t prod;
  logic            tag_valid;
  logic            tag_first;
  logic            tag_hi;
  eotf_pkg::acc_t  addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= op.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= a * b;
    tag_first <= op.first;
    tag_hi    <= op.hi;
  end

  // upper partial sits 24 bits up
  always_comb begin
    addend = eotf_pkg::acc_t'(prod);
    if (tag_hi) begin
      addend = addend <<< eotf_pkg::LoBits;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_valid) begin
      acc <= tag_first ? addend : acc + addend;
    end
  end

endmodule

// File: rtl/eotf_div.sv
// eotf_div: restoring divider, one quotient bit per cycle, floor(n * 2^17 / d)
// held at 2^24; depends on eotf_pkg
`timescale 1ns / 1ps

module eotf_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [eotf_pkg::RatioBits-1:0]       dividend,
  input  logic [eotf_pkg::RatioBits-1:0]       divisor,
  output logic                                 busy,
  output logic [eotf_pkg::QWideBits-1:0]       quotient
);

  logic [eotf_pkg::RatioBits-1:0]    rem;
  logic [eotf_pkg::QWideBits-1:0]    bits;
  logic [eotf_pkg::QWideBits-1:0]    q;
  logic [eotf_pkg::DivCountBits-1:0] count;
  logic                              ovf;
  logic [eotf_pkg::RatioBits:0]      trial;
  logic [eotf_pkg::RatioBits:0]      dwide;
  logic [eotf_pkg::RatioBits-1:0]    head;

  assign busy  = (count != '0);
  assign trial = {rem, bits[eotf_pkg::QWideBits-1]};
  assign dwide = {1'b0, divisor};
  // dividend bits above the quotient window; a prefix at or above the divisor means overflow
  assign head  = dividend >> eotf_pkg::DivPreShift;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= eotf_pkg::DivCountBits'(eotf_pkg::DivSteps);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= head;
      bits <= {dividend[eotf_pkg::DivPreShift-1:0],
               {(eotf_pkg::QWideBits - eotf_pkg::DivPreShift){1'b0}}};
      q    <= '0;
      ovf  <= (head >= divisor);
    end else if (busy) begin
      bits <= bits << 1;
      if (trial >= dwide) begin
        rem <= eotf_pkg::RatioBits'(trial - dwide);
        q   <= {q[eotf_pkg::QWideBits-2:0], 1'b1};
      end else begin
        rem <= trial[eotf_pkg::RatioBits-1:0];
        q   <= {q[eotf_pkg::QWideBits-2:0], 1'b0};
      end
    end
  end

  assign quotient = (ovf || q > eotf_pkg::DivLimit) ? eotf_pkg::DivLimit : q;

endmodule
